[rtl/rpn_stack_calculator_assert.svh]
// assertion macros used by the rpn stack calculator checker
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define RSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpn stack calculator check failed");

// consequent checked in the cycle after the antecedent
`define RSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpn stack calculator check failed");

`endif

[rtl/rsc_pkg.sv]
// types and constants shared by the rpn stack calculator modules
package rsc_pkg;

    localparam int DATA_W    = 32;
    localparam int CMD_W     = 4;
    localparam int STATUS_W  = 3;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH      = 4'd0,
        CMD_ADD       = 4'd1,
        CMD_SUB       = 4'd2,
        CMD_MUL       = 4'd3,
        CMD_DIV       = 4'd4,
        CMD_ABS       = 4'd5,
        CMD_NEG       = 4'd6,
        CMD_DUP       = 4'd7,
        CMD_CLEAR     = 4'd8,
        CMD_PRINT_TOP = 4'd9,
        CMD_PRINT_ALL = 4'd10
    } t_cmd_code;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_EMPTY         = 3'd1,
        ST_ALREADY_EMPTY = 3'd2,
        ST_TOO_FEW       = 3'd3,
        ST_DIV_ZERO      = 3'd4,
        ST_FULL          = 3'd5
    } t_status;

    // stack address sources
    typedef enum logic [2:0] {
        AS_CNT,
        AS_CNT_M1,
        AS_CNT_M2,
        AS_CNT_M3,
        AS_PTR
    } t_addr_sel;

    // stack write data sources
    typedef enum logic [2:0] {
        WD_OPND,
        WD_TOP,
        WD_NEG,
        WD_ABS,
        WD_RES
    } t_wd_sel;

    typedef enum logic [2:0] {
        CO_HOLD,
        CO_INC,
        CO_DEC1,
        CO_DEC2,
        CO_CLR
    } t_cnt_op;

    typedef enum logic [1:0] {
        RS_ADD,
        RS_SUB,
        RS_MUL,
        RS_DIVQ
    } t_res_sel;

    typedef enum logic {
        OS_TOP,
        OS_RD
    } t_out_src;

    // controller to datapath
    typedef struct packed {
        logic      in_ld;
        logic      rd_en;
        t_addr_sel rd_sel;
        logic      wr_en;
        t_addr_sel wr_sel;
        t_wd_sel   wd_sel;
        logic      top_ld;
        logic      top_from_rd;
        t_cnt_op   cnt_op;
        logic      ptr_ld;
        logic      ptr_dec;
        logic      res_ld;
        t_res_sel  res_sel;
        logic      div_start;
        logic      div_step;
        logic      out_ld;
        t_out_src  out_src;
        t_status   out_status;
        logic      out_last;
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic cnt_lt2;
        logic cnt_lt3;
        logic cnt_full;
        logic s_zero;
        logic div_last;
        logic ptr_zero;
    } t_dp_sts;

endpackage

[rtl/rpn_stack_calculator.sv]
// rpn stack calculator top level: command sequencer plus stack datapath
// requests: decode in the exec state, then the emit state loads the output register;
// add, sub and mul first pass an operand and a write-back state, and div also runs
// the 32-step one-bit-per-cycle divider; a new request is taken only back in idle
// print all alternates a stack read and an emit per value (single stack read port)
// synchronous active-low reset empties the stack; stored words are not cleared
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request side
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [rsc_pkg::CMD_W-1:0]           i_command,
    input  logic signed [rsc_pkg::DATA_W-1:0]   i_operand,
    // result side
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [rsc_pkg::DATA_W-1:0]   o_value,
    output logic [rsc_pkg::STATUS_W-1:0]        o_status,
    output logic                                o_last
);
    import rsc_pkg::*;

    // command and status bundles between sequencer and datapath
    t_dp_ctl ctl;
    t_dp_sts sts;

    // sequencer: decodes the request, steps the divider and the print-all walk,
    // and holds the result valid flag so a finished result can wait while the
    // next request is taken
    rsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    // datapath: single-port-write, registered-read stack memory with the top
    // cached in a register, adder, 32x32 multiplier, radix-2 divider and the
    // result payload register
    rsc_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_operand (i_operand),
        .i_ctl     (ctl),
        .o_sts     (sts),
        .o_value   (o_value),
        .o_status  (o_status),
        .o_last    (o_last)
    );

endmodule

[rtl/rsc_datapath.sv]
// stack memory, top register, alu and radix-2 divider of the calculator
module rsc_datapath #(
    parameter int STACK_DEPTH = 64,
    localparam int AW = $clog2(STACK_DEPTH),
    localparam int CW = $clog2(STACK_DEPTH + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [rsc_pkg::DATA_W-1:0]   i_operand,
    input  rsc_pkg::t_dp_ctl                    i_ctl,
    output rsc_pkg::t_dp_sts                    o_sts,
    output logic signed [rsc_pkg::DATA_W-1:0]   o_value,
    output logic [rsc_pkg::STATUS_W-1:0]        o_status,
    output logic                                o_last
);
    import rsc_pkg::*;

    logic [DATA_W-1:0]    r_mem [STACK_DEPTH];
    logic [DATA_W-1:0]    r_rd;
    logic [DATA_W-1:0]    r_top;
    logic [DATA_W-1:0]    r_opnd;
    logic [DATA_W-1:0]    r_res;
    logic [DATA_W-1:0]    r_dvd;
    logic [DATA_W-1:0]    r_dvs;
    logic [DATA_W-1:0]    r_rem;
    logic                 r_qneg;
    logic [DIV_CNT_W-1:0] r_dcnt;
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        n_cnt;
    logic [AW-1:0]        r_ptr;
    logic [DATA_W-1:0]    r_out_value;
    logic [STATUS_W-1:0]  r_out_status;
    logic                 r_out_last;

    logic [CW-1:0]        cnt_m1;
    logic [CW-1:0]        cnt_m2;
    logic [CW-1:0]        cnt_m3;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [DATA_W-1:0]    wdata;
    logic [DATA_W-1:0]    top_neg;
    logic [DATA_W-1:0]    top_or_zero;
    logic [DATA_W:0]      rem_sh;
    logic [DATA_W:0]      rem_diff;

    assign cnt_m1 = r_cnt - CW'(1);
    assign cnt_m2 = r_cnt - CW'(2);
    assign cnt_m3 = r_cnt - CW'(3);

    function automatic logic [AW-1:0] pick_addr(
        input t_addr_sel sel,
        input logic [CW-1:0] cnt,
        input logic [CW-1:0] m1,
        input logic [CW-1:0] m2,
        input logic [CW-1:0] m3,
        input logic [AW-1:0] ptr
    );
        logic [AW-1:0] a;
        unique case (sel)
            AS_CNT:    a = cnt[AW-1:0];
            AS_CNT_M1: a = m1[AW-1:0];
            AS_CNT_M2: a = m2[AW-1:0];
            AS_CNT_M3: a = m3[AW-1:0];
            AS_PTR:    a = ptr;
            default:   a = ptr;
        endcase
        return a;
    endfunction

    assign rd_addr = pick_addr(i_ctl.rd_sel, r_cnt, cnt_m1, cnt_m2, cnt_m3, r_ptr);
    assign wr_addr = pick_addr(i_ctl.wr_sel, r_cnt, cnt_m1, cnt_m2, cnt_m3, r_ptr);

    assign top_neg     = DATA_W'(0) - r_top;
    assign top_or_zero = (r_cnt == '0) ? '0 : r_top;

    always_comb begin
        case (i_ctl.wd_sel)
            WD_OPND: wdata = r_opnd;
            WD_TOP:  wdata = r_top;
            WD_NEG:  wdata = top_neg;
            WD_ABS:  wdata = r_top[DATA_W-1] ? top_neg : r_top;
            default: wdata = r_res;
        endcase
    end

    // one restoring step per cycle, quotient bits shift in behind the dividend
    assign rem_sh   = {r_rem, r_dvd[DATA_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_dvs};

    always_comb begin
        case (i_ctl.cnt_op)
            CO_INC:  n_cnt = r_cnt + CW'(1);
            CO_DEC1: n_cnt = cnt_m1;
            CO_DEC2: n_cnt = cnt_m2;
            CO_CLR:  n_cnt = '0;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[wr_addr] <= wdata;
        end
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_dcnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_ctl.div_start) begin
                r_dcnt <= '0;
            end else if (i_ctl.div_step) begin
                r_dcnt <= r_dcnt + DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.in_ld) begin
            r_opnd <= i_operand;
        end
        if (i_ctl.top_ld) begin
            r_top <= wdata;
        end else if (i_ctl.top_from_rd) begin
            r_top <= r_rd;
        end
        if (i_ctl.ptr_ld) begin
            r_ptr <= cnt_m1[AW-1:0];
        end else if (i_ctl.ptr_dec) begin
            r_ptr <= r_ptr - AW'(1);
        end
        if (i_ctl.res_ld) begin
            case (i_ctl.res_sel)
                RS_ADD:  r_res <= r_top + r_rd;
                RS_SUB:  r_res <= r_top - r_rd;
                RS_MUL:  r_res <= DATA_W'(r_top * r_rd);
                default: r_res <= r_qneg ? DATA_W'(0) - r_dvd : r_dvd;
            endcase
        end
        if (i_ctl.div_start) begin
            r_dvd  <= r_top[DATA_W-1] ? top_neg : r_top;
            r_dvs  <= r_rd[DATA_W-1] ? DATA_W'(0) - r_rd : r_rd;
            r_rem  <= '0;
            r_qneg <= r_top[DATA_W-1] ^ r_rd[DATA_W-1];
        end else if (i_ctl.div_step) begin
            if (!rem_diff[DATA_W]) begin
                r_rem <= rem_diff[DATA_W-1:0];
                r_dvd <= {r_dvd[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DATA_W-1:0];
                r_dvd <= {r_dvd[DATA_W-2:0], 1'b0};
            end
        end
        if (i_ctl.out_ld) begin
            r_out_value  <= (i_ctl.out_src == OS_RD) ? r_rd : top_or_zero;
            r_out_status <= i_ctl.out_status;
            r_out_last   <= i_ctl.out_last;
        end
    end

    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.cnt_lt2  = (r_cnt < CW'(2));
    assign o_sts.cnt_lt3  = (r_cnt < CW'(3));
    assign o_sts.cnt_full = (r_cnt == CW'(STACK_DEPTH));
    assign o_sts.s_zero   = (r_rd == '0);
    assign o_sts.div_last = &r_dcnt;
    assign o_sts.ptr_zero = (r_ptr == '0);

    assign o_value  = r_out_value;
    assign o_status = r_out_status;
    assign o_last   = r_out_last;

endmodule

[rtl/rsc_ctrl.sv]
// command sequencer of the calculator
module rsc_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rsc_pkg::CMD_W-1:0]     i_command,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  rsc_pkg::t_dp_sts              i_sts,
    output rsc_pkg::t_dp_ctl              o_ctl
);
    import rsc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_OPER,
        S_DIV,
        S_DIVQ,
        S_WB,
        S_RDTOP,
        S_EMIT,
        S_PRD,
        S_PEMIT
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CMD_W-1:0] r_cmd;
    t_status          r_st;
    t_status          n_st;
    logic             r_out_valid;
    logic             accept;
    logic             out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.in_ld = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_EMIT;
                n_st    = ST_OK;
                unique case (r_cmd) inside
                    CMD_PUSH: begin
                        if (i_sts.cnt_full) begin
                            n_st = ST_FULL;
                        end else begin
                            o_ctl.wr_en  = 1'b1;
                            o_ctl.wr_sel = AS_CNT;
                            o_ctl.wd_sel = WD_OPND;
                            o_ctl.top_ld = 1'b1;
                            o_ctl.cnt_op = CO_INC;
                        end
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                        if (i_sts.cnt_lt2) begin
                            n_st = ST_TOO_FEW;
                        end else begin
                            o_ctl.rd_en  = 1'b1;
                            o_ctl.rd_sel = AS_CNT_M2;
                            n_state      = S_OPER;
                        end
                    end
                    CMD_ABS, CMD_NEG: begin
                        if (i_sts.cnt_zero) begin
                            n_st = ST_EMPTY;
                        end else begin
                            o_ctl.wr_en  = 1'b1;
                            o_ctl.wr_sel = AS_CNT_M1;
                            o_ctl.wd_sel = (r_cmd == CMD_NEG) ? WD_NEG : WD_ABS;
                            o_ctl.top_ld = 1'b1;
                        end
                    end
                    CMD_DUP: begin
                        if (i_sts.cnt_zero) begin
                            n_st = ST_EMPTY;
                        end else if (i_sts.cnt_full) begin
                            n_st = ST_FULL;
                        end else begin
                            o_ctl.wr_en  = 1'b1;
                            o_ctl.wr_sel = AS_CNT;
                            o_ctl.wd_sel = WD_TOP;
                            o_ctl.cnt_op = CO_INC;
                        end
                    end
                    CMD_CLEAR: begin
                        if (i_sts.cnt_zero) begin
                            n_st = ST_ALREADY_EMPTY;
                        end else begin
                            o_ctl.cnt_op = CO_CLR;
                        end
                    end
                    CMD_PRINT_TOP: begin
                        if (i_sts.cnt_zero) begin
                            n_st = ST_EMPTY;
                        end
                    end
                    CMD_PRINT_ALL: begin
                        if (i_sts.cnt_zero) begin
                            n_st = ST_EMPTY;
                        end else begin
                            o_ctl.ptr_ld = 1'b1;
                            n_state      = S_PRD;
                        end
                    end
                    default: begin
                        n_st = ST_OK;
                    end
                endcase
            end
            S_OPER: begin
                unique case (r_cmd) inside
                    CMD_DIV: begin
                        if (i_sts.s_zero) begin
                            o_ctl.cnt_op = CO_DEC2;
                            n_st         = ST_DIV_ZERO;
                            if (i_sts.cnt_lt3) begin
                                n_state = S_EMIT;
                            end else begin
                                o_ctl.rd_en  = 1'b1;
                                o_ctl.rd_sel = AS_CNT_M3;
                                n_state      = S_RDTOP;
                            end
                        end else begin
                            o_ctl.div_start = 1'b1;
                            n_state         = S_DIV;
                        end
                    end
                    CMD_MUL: begin
                        o_ctl.res_ld  = 1'b1;
                        o_ctl.res_sel = RS_MUL;
                        n_state       = S_WB;
                    end
                    CMD_SUB: begin
                        o_ctl.res_ld  = 1'b1;
                        o_ctl.res_sel = RS_SUB;
                        n_state       = S_WB;
                    end
                    default: begin
                        o_ctl.res_ld  = 1'b1;
                        o_ctl.res_sel = RS_ADD;
                        n_state       = S_WB;
                    end
                endcase
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DIVQ;
                end
            end
            S_DIVQ: begin
                o_ctl.res_ld  = 1'b1;
                o_ctl.res_sel = RS_DIVQ;
                n_state       = S_WB;
            end
            S_WB: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wr_sel = AS_CNT_M2;
                o_ctl.wd_sel = WD_RES;
                o_ctl.top_ld = 1'b1;
                o_ctl.cnt_op = CO_DEC1;
                n_st         = ST_OK;
                n_state      = S_EMIT;
            end
            S_RDTOP: begin
                o_ctl.top_from_rd = 1'b1;
                n_state           = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_ctl.out_ld     = 1'b1;
                    o_ctl.out_src    = OS_TOP;
                    o_ctl.out_status = r_st;
                    o_ctl.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_PRD: begin
                o_ctl.rd_en  = 1'b1;
                o_ctl.rd_sel = AS_PTR;
                n_state      = S_PEMIT;
            end
            S_PEMIT: begin
                if (out_free) begin
                    o_ctl.out_ld     = 1'b1;
                    o_ctl.out_src    = OS_RD;
                    o_ctl.out_status = ST_OK;
                    o_ctl.out_last   = i_sts.ptr_zero;
                    if (i_sts.ptr_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ctl.ptr_dec = 1'b1;
                        n_state       = S_PRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
            if (accept) begin
                r_cmd <= i_command;
            end
            if (o_ctl.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/rsc_checker.sv]
// port-level checks for the rpn stack calculator, bound to the top level
`include "rpn_stack_calculator_assert.svh"

module rsc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic [rsc_pkg::CMD_W-1:0]           i_command,
    input logic signed [rsc_pkg::DATA_W-1:0]   i_operand,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [rsc_pkg::DATA_W-1:0]   o_value,
    input logic [rsc_pkg::STATUS_W-1:0]        o_status,
    input logic                                o_last
);
    import rsc_pkg::*;

    // one request at a time: no request taken in the cycle after one
    `RSC_ASSERT_NEXT(a_one_request, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // every error status ends its request
    `RSC_ASSERT_SAME(a_error_last, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, o_last)

    // no new request while a stalled print-all value still has more behind it
    `RSC_ASSERT_NEXT(a_run_blocks, i_clk, i_rst_n,
        o_out_valid && !o_last && !i_out_ready, !o_in_ready)

    // status codes stay within the defined set
    `RSC_ASSERT_SAME(a_status_code, i_clk, i_rst_n, o_out_valid, o_status <= ST_FULL)

    // a stalled result holds
    `RSC_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_value) && $stable(o_status) && $stable(o_last))

endmodule

bind rpn_stack_calculator rsc_checker u_rsc_checker (.*);

[sim/rpn_stack_calculator_test.sv]
// self-checking testbench for the rpn stack calculator: directed and random requests
`timescale 1ns / 100ps

module rpn_stack_calculator_test;
    import rsc_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    // longest quiet spell after the last result: divider latency with margin
    localparam int TAIL_CYCLES = 48;

    // command codes with no operation behind them
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd11;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

    localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] WORD_MAX = 32'h7fff_ffff;

    // ------------------------------------------------------------------
    // predicted stack and the queue of results still owed by the block
    // ------------------------------------------------------------------
    class calc_scoreboard;
        typedef struct {
            logic [DATA_W-1:0] value;
            t_status           status;
            logic              last;
        } t_calc_result;

        logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
        int unsigned       depth_used;
        t_calc_result      owed_results [$];
        int unsigned       error_count;

        function new();
            depth_used  = 0;
            error_count = 0;
        endfunction

        function logic [DATA_W-1:0] top_or_zero();
            if (depth_used == 0) begin
                return '0;
            end
            return stack_mem[depth_used-1];
        endfunction

        function void owe(logic [DATA_W-1:0] value, t_status status, logic last = 1'b1);
            t_calc_result res;
            res.value  = value;
            res.status = status;
            res.last   = last;
            owed_results.push_back(res);
        endfunction

        // apply one accepted request to the predicted stack
        function void note_request(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] opnd);
            logic [DATA_W-1:0] t;
            logic [DATA_W-1:0] s;
            logic [DATA_W-1:0] r;
            longint            quot;
            case (cmd) inside
                CMD_PUSH: begin
                    if (depth_used >= STACK_DEPTH) begin
                        owe(top_or_zero(), ST_FULL);
                    end else begin
                        stack_mem[depth_used] = opnd;
                        depth_used++;
                        owe(top_or_zero(), ST_OK);
                    end
                end
                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                    if (depth_used < 2) begin
                        owe(top_or_zero(), ST_TOO_FEW);
                    end else begin
                        // top op second
                        t = stack_mem[depth_used-1];
                        s = stack_mem[depth_used-2];
                        depth_used -= 2;
                        if (cmd == CMD_DIV && s == '0) begin
                            owe(top_or_zero(), ST_DIV_ZERO);
                        end else begin
                            case (cmd)
                                CMD_ADD: r = t + s;
                                CMD_SUB: r = t - s;
                                CMD_MUL: r = t * s;
                                default: begin
                                    // 64-bit quotient so min over -1 wraps cleanly
                                    quot = longint'($signed(t)) / longint'($signed(s));
                                    r = quot[DATA_W-1:0];
                                end
                            endcase
                            stack_mem[depth_used] = r;
                            depth_used++;
                            owe(r, ST_OK);
                        end
                    end
                end
                CMD_ABS, CMD_NEG: begin
                    if (depth_used == 0) begin
                        owe('0, ST_EMPTY);
                    end else begin
                        t = stack_mem[depth_used-1];
                        if (cmd == CMD_NEG || t[DATA_W-1]) begin
                            t = '0 - t;
                        end
                        stack_mem[depth_used-1] = t;
                        owe(t, ST_OK);
                    end
                end
                CMD_DUP: begin
                    if (depth_used == 0) begin
                        owe('0, ST_EMPTY);
                    end else if (depth_used >= STACK_DEPTH) begin
                        owe(top_or_zero(), ST_FULL);
                    end else begin
                        stack_mem[depth_used] = stack_mem[depth_used-1];
                        depth_used++;
                        owe(top_or_zero(), ST_OK);
                    end
                end
                CMD_CLEAR: begin
                    if (depth_used == 0) begin
                        owe('0, ST_ALREADY_EMPTY);
                    end else begin
                        depth_used = 0;
                        owe('0, ST_OK);
                    end
                end
                CMD_PRINT_TOP: begin
                    if (depth_used == 0) begin
                        owe('0, ST_EMPTY);
                    end else begin
                        owe(top_or_zero(), ST_OK);
                    end
                end
                CMD_PRINT_ALL: begin
                    if (depth_used == 0) begin
                        owe('0, ST_EMPTY);
                    end else begin
                        for (int i = depth_used; i > 0; i--) begin
                            owe(stack_mem[i-1], ST_OK, i == 1);
                        end
                    end
                end
                default: owe(top_or_zero(), ST_OK);
            endcase
        endfunction

        function void check_result(logic [DATA_W-1:0] value, logic [STATUS_W-1:0] status,
                                   logic last);
            t_calc_result want;
            if (owed_results.size() == 0) begin
                $display("%0t: result expected none actual value %h status %0d last %b",
                         $time, value, status, last);
                error_count++;
                return;
            end
            want = owed_results.pop_front();
            if (value !== want.value) begin
                $display("%0t: value expected %h actual %h", $time, want.value, value);
                error_count++;
            end
            if (status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                error_count++;
            end
            if (last !== want.last) begin
                $display("%0t: last expected %b actual %b", $time, want.last, last);
                error_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic [CMD_W-1:0]         i_command   = '0;
    logic signed [DATA_W-1:0] i_operand   = '0;
    logic                     i_out_ready = 1'b0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    logic signed [DATA_W-1:0] o_value;
    logic [STATUS_W-1:0]      o_status;
    logic                     o_last;

    calc_scoreboard board = new();

    // no idling on either side once the tail of the run starts
    bit          quiet_tail    = 1'b0;
    int unsigned requests_sent = 0;
    int unsigned fills_done    = 0;
    int unsigned idle_cycles   = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    rpn_stack_calculator #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_operand   (i_operand),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    // ------------------------------------------------------------------
    // result side: compare every accepted result, watch for a hang
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_ready) begin
                board.check_result(o_value, o_status, o_last);
            end
            // anything moving on either side restarts the count
            if ((o_out_valid === 1'b1 && i_out_ready) ||
                (i_in_valid && o_in_ready === 1'b1)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // receiver back-pressure: random stall bursts of random length
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // present one request at the falling edge and hold it until taken
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] opnd);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_command  = cmd;
        i_operand  = opnd;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) begin
            @(posedge i_clk);
        end
        board.note_request(cmd, opnd);
        requests_sent++;
    endtask

    // sender gap with junk on the payload, which the block must ignore
    task automatic sender_gap();
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            i_command  = CMD_W'($urandom);
            i_operand  = $urandom;
            repeat ($urandom_range(1, 11) - 1) @(negedge i_clk);
        end
    endtask

    // hold off new requests until every owed result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.owed_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // biased towards the corners of the signed range
    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd1;
            2:       return '1;
            3:       return WORD_MIN;
            4:       return WORD_MAX;
            5:       return $urandom_range(0, 20);
            6:       return '0 - $urandom_range(1, 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(input logic [CMD_W-1:0] cmd);
        sender_gap();
        send_request(cmd, (cmd == CMD_PUSH) ? pick_operand() : $urandom);
    endtask

    // arithmetic-heavy runs: mostly pushes followed by operations on them
    task automatic run_random(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned n;
        stop_at = requests_sent + n_items;
        while (requests_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    n = $urandom_range(1, 4);
                    repeat (n) send_random(CMD_PUSH);
                    n = $urandom_range(1, 3);
                    repeat (n) send_random(CMD_W'($urandom_range(CMD_ADD, CMD_DUP)));
                end
                5: send_random($urandom_range(0, 1) ? CMD_PRINT_TOP : CMD_PRINT_ALL);
                6: send_random(CMD_W'($urandom_range(0, 15)));
                7: begin
                    // broken sequence: a clear half of the time, then an operation, short of operands after the clear
                    if ($urandom_range(0, 1)) begin
                        send_random(CMD_CLEAR);
                    end
                    send_random(CMD_W'($urandom_range(CMD_ADD, CMD_DIV)));
                end
                8: begin
                    // divisor pushed first, so it sits second from the top
                    sender_gap();
                    send_request(CMD_PUSH, $urandom_range(0, 2) == 0 ? '0 : pick_operand());
                    send_random(CMD_PUSH);
                    send_random(CMD_DIV);
                end
                default: begin
                    if (fills_done < 2) begin
                        // fill to the brim, then bump into the ceiling
                        while (board.depth_used < STACK_DEPTH) begin
                            send_random(CMD_PUSH);
                        end
                        send_random(CMD_PUSH);
                        send_random(CMD_DUP);
                        send_random(CMD_PRINT_ALL);
                        send_random(CMD_CLEAR);
                        fills_done++;
                    end else begin
                        send_random(CMD_PRINT_ALL);
                    end
                end
            endcase
            // keep the stack shallow outside the fill runs
            if (board.depth_used > 40 && $urandom_range(0, 1)) begin
                send_random(CMD_CLEAR);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: print, unary, dup, clear, sub and a spare code on an empty stack first
        send_request(CMD_PRINT_TOP, '0);
        send_request(CMD_PRINT_ALL, '0);
        send_request(CMD_ABS, '0);
        send_request(CMD_NEG, '1);
        send_request(CMD_DUP, '0);
        send_request(CMD_CLEAR, '0);
        send_request(CMD_SUB, '0);
        send_request(CMD_SPARE_LO, WORD_MAX);
        // most negative value: too few operands, abs and negate both wrap
        send_request(CMD_PUSH, WORD_MIN);
        send_request(CMD_ADD, '0);
        send_request(CMD_ABS, '0);
        send_request(CMD_NEG, '0);
        send_request(CMD_CLEAR, '0);
        // most negative over minus one wraps
        send_request(CMD_PUSH, '1);
        send_request(CMD_PUSH, WORD_MIN);
        send_request(CMD_DIV, '0);
        // zero divisor drops both operands
        send_request(CMD_PUSH, '0);
        send_request(CMD_PUSH, 32'd5);
        send_request(CMD_DIV, '0);
        // wrapping add and multiply on the largest value
        send_request(CMD_PUSH, WORD_MAX);
        send_request(CMD_DUP, '0);
        send_request(CMD_ADD, '0);
        send_request(CMD_PUSH, WORD_MAX);
        send_request(CMD_MUL, '0);
        send_request(CMD_PRINT_ALL, '0);
        send_request(CMD_SPARE_HI, '0);
        send_request(CMD_CLEAR, '0);

        drain_results();

        // random part with idling on both sides
        run_random(90);
        drain_results();
        run_random(55);

        // tail without idling
        quiet_tail = 1'b1;
        run_random(40);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (board.error_count == 0 && board.owed_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/rsc_pkg.sv
rtl/rsc_datapath.sv
rtl/rsc_ctrl.sv
rtl/rpn_stack_calculator.sv
rtl/rsc_checker.sv
sim/rpn_stack_calculator_test.sv
